// ----- rtl/core/ncb_pkg.sv -----
// types and constants shared by the negative cache modules
`default_nettype none
package ncb_pkg;

  localparam int ENTRIES = 256;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int KEY_W   = 64;
  localparam int MS_W    = 32;

  localparam logic [MS_W-1:0] BACKOFF_RST = 32'd10000;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_RECORD = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_TEMP = 2'd1,
    KIND_PERM = 2'd2
  } kind_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] stamp;
    logic [MS_W-1:0]  rec_ms;
    kind_t            kind;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic  blocked;
    kind_t kind;
    logic  inval;
    logic  wr;
    logic  clr;
  } eval_t;

endpackage
`default_nettype wire

// ----- rtl/core/negative_cache_with_backoff.sv -----
// top level of the direct-mapped negative cache with backoff
//
//   port group   direction  handshake              carries
//   in_*         in         in_valid / in_ready    opcode, key, stamp, kind, now
//   out_*        out        out_valid / out_ready  blocked, block_kind
//   cfg_*        in         cfg_valid / cfg_ready  backoff_ms
//
// one request per cycle sustained while out_ready holds; a result is registered first
// in the ram read and request registers, then in the result register
// reset clears the entry valid bits at once, no sweep; clear does the same
// a stalled result holds the request register, which then stops intake
`default_nettype none
module negative_cache_with_backoff (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_opcode,
  input  wire logic [ncb_pkg::KEY_W-1:0]   in_song_key,
  input  wire logic [ncb_pkg::KEY_W-1:0]   in_source_stamp,
  input  wire logic [1:0]                  in_fail_kind,
  input  wire logic [ncb_pkg::MS_W-1:0]    in_now_ms,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_blocked,
  output logic [1:0]                       out_block_kind,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ncb_pkg::MS_W-1:0]    cfg_backoff_ms
);

  import ncb_pkg::*;

  logic [MS_W-1:0]    backoff_r;
  logic               s1_vld_r;
  logic [1:0]         s1_op_r;
  logic [KEY_W-1:0]   s1_key_r;
  logic [KEY_W-1:0]   s1_stamp_r;
  logic [1:0]         s1_kind_r;
  logic [MS_W-1:0]    s1_now_r;
  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] valid_nxt;
  logic               fwd_hit_r;
  entry_t             fwd_ent_r;
  logic               out_vld_r;
  logic               out_blk_r;
  logic [1:0]         out_kind_r;

  logic               in_fire;
  logic               s1_fire;
  logic [IDX_W-1:0]   s1_idx;
  logic [IDX_W-1:0]   in_idx;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             wr_ent;
  entry_t             cur_ent;
  eval_t              ev;

  assign s1_idx    = s1_key_r[IDX_W-1:0];
  assign in_idx    = in_song_key[IDX_W-1:0];
  assign s1_fire   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !s1_vld_r || s1_fire;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign wr_ent  = '{key: s1_key_r, stamp: s1_stamp_r, rec_ms: s1_now_r,
                     kind: kind_t'(s1_kind_r)};
  assign cur_ent = fwd_hit_r ? fwd_ent_r : entry_t'(ram_rdata);

  ncb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (s1_fire && ev.wr),
    .waddr (s1_idx),
    .wdata (wr_ent),
    .re    (in_fire),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  ncb_eval u_eval (
    .op         (s1_op_r),
    .key        (s1_key_r),
    .stamp      (s1_stamp_r),
    .fail_kind  (s1_kind_r),
    .now_ms     (s1_now_r),
    .backoff_ms (backoff_r),
    .ent        (cur_ent),
    .ent_vld    (valid_r[s1_idx]),
    .res        (ev)
  );

  always_comb begin
    valid_nxt = valid_r;
    if (s1_fire) begin
      if (ev.clr) begin
        valid_nxt = '0;
      end else if (ev.wr) begin
        valid_nxt[s1_idx] = 1'b1;
      end else if (ev.inval) begin
        valid_nxt[s1_idx] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backoff_r <= BACKOFF_RST;
      s1_vld_r  <= 1'b0;
      valid_r   <= '0;
      out_vld_r <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        backoff_r <= cfg_backoff_ms;
      end
      valid_r <= valid_nxt;
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (in_fire) begin
        fwd_hit_r <= s1_fire && ev.wr && (s1_idx == in_idx);
      end
      if (s1_fire) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // request payload, write forward and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= in_opcode;
      s1_key_r   <= in_song_key;
      s1_stamp_r <= in_source_stamp;
      s1_kind_r  <= in_fail_kind;
      s1_now_r   <= in_now_ms;
      fwd_ent_r  <= wr_ent;
    end
    if (s1_fire) begin
      out_blk_r  <= ev.blocked;
      out_kind_r <= ev.kind;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_blocked    = out_blk_r;
  assign out_block_kind = out_kind_r;

  a_clear_wipes: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && ev.clr |=> valid_r == '0)
    else $error("clear left a valid entry");

  a_record_sets: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && ev.wr |=> valid_r[$past(s1_idx)])
    else $error("record did not mark its entry valid");

  a_kind_needs_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_blk_r |-> out_kind_r == KIND_NONE)
    else $error("kind reported without block");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_vld_r)
    else $error("accepted request lost before evaluation");

endmodule
`default_nettype wire

// ----- rtl/core/ncb_ram.sv -----
// generic single write port ram with registered read
`default_nettype none
module ncb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/ncb_eval.sv -----
// decision logic for one request against its cache entry
`default_nettype none
module ncb_eval (
  input  wire logic [1:0]               op,
  input  wire logic [ncb_pkg::KEY_W-1:0] key,
  input  wire logic [ncb_pkg::KEY_W-1:0] stamp,
  input  wire logic [1:0]               fail_kind,
  input  wire logic [ncb_pkg::MS_W-1:0]  now_ms,
  input  wire logic [ncb_pkg::MS_W-1:0]  backoff_ms,
  input  wire ncb_pkg::entry_t           ent,
  input  wire logic                      ent_vld,
  output ncb_pkg::eval_t                 res
);

  import ncb_pkg::*;

  logic            key_pos;
  logic            stamp_pos;
  logic            hit;
  logic            newer;
  logic [MS_W-1:0] elapsed;

  assign key_pos   = !key[KEY_W-1] && (key != '0);
  assign stamp_pos = !stamp[KEY_W-1] && (stamp != '0);
  assign hit       = ent_vld && (ent.key == key);
  assign newer     = stamp_pos && ($signed(stamp) > $signed(ent.stamp));
  assign elapsed   = now_ms - ent.rec_ms;

  always_comb begin
    res = '{blocked: 1'b0, kind: KIND_NONE, inval: 1'b0, wr: 1'b0, clr: 1'b0};
    unique case (op)
      OP_LOOKUP: begin
        if (!key_pos) begin
          res.blocked = 1'b1;
        end else if (hit) begin
          if (newer) begin
            res.inval = 1'b1;
          end else if (ent.kind == KIND_PERM) begin
            res.blocked = 1'b1;
            res.kind    = KIND_PERM;
          end else if (ent.kind == KIND_TEMP) begin
            if (elapsed < backoff_ms) begin
              res.blocked = 1'b1;
              res.kind    = KIND_TEMP;
            end else begin
              res.inval = 1'b1;
            end
          end
        end
      end
      OP_RECORD: begin
        res.wr = key_pos && (fail_kind == KIND_TEMP || fail_kind == KIND_PERM);
      end
      OP_CLEAR: begin
        res.clr = 1'b1;
      end
      default: begin
        res.clr = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- bench/negative_cache_with_backoff_tb.sv -----
// testbench for the negative cache with backoff: directed and random requests, scored in order
`timescale 1ns / 100ps
module negative_cache_with_backoff_tb;
  import ncb_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;
  localparam int HOT_KEYS = 12;
  localparam int PHASE_ITEMS = 135;

  typedef struct packed {
    logic  blocked;
    kind_t kind;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = '0;
  logic [63:0] in_song_key = '0;
  logic [63:0] in_source_stamp = '0;
  logic [1:0]  in_fail_kind = '0;
  logic [31:0] in_now_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_blocked;
  logic [1:0]  out_block_kind;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_backoff_ms = '0;

  kind_t       cache_kind [ENTRIES];
  logic [63:0] cache_key [ENTRIES];
  logic [63:0] cache_stamp [ENTRIES];
  logic [31:0] cache_time [ENTRIES];
  logic [31:0] backoff_model = BACKOFF_RST;

  verdict_t    expected_verdicts [$];
  logic [63:0] hot_keys [HOT_KEYS];
  int          mismatch_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  negative_cache_with_backoff uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_song_key     (in_song_key),
    .in_source_stamp (in_source_stamp),
    .in_fail_kind    (in_fail_kind),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_blocked     (out_blocked),
    .out_block_kind  (out_block_kind),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_backoff_ms  (cfg_backoff_ms)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void wipe_cache();
    foreach (cache_kind[i]) begin
      cache_kind[i] = KIND_NONE;
      cache_key[i] = '0;
      cache_stamp[i] = '0;
      cache_time[i] = '0;
    end
  endfunction

  function automatic verdict_t predict_verdict(input logic [1:0] op, input logic [63:0] key,
      input logic [63:0] stamp, input logic [1:0] kind, input logic [31:0] now);
    verdict_t    v;
    int unsigned slot;
    logic        key_ok;
    logic [31:0] elapsed;
    v.blocked = 1'b0;
    v.kind = KIND_NONE;
    key_ok = (key != '0) && !key[63];
    slot = int'(key % ENTRIES);
    case (op)
      OP_LOOKUP: begin
        if (!key_ok) begin
          v.blocked = 1'b1;
        end else if (cache_key[slot] == key && cache_kind[slot] != KIND_NONE) begin
          elapsed = now - cache_time[slot];
          if (stamp != '0 && !stamp[63] && $signed(stamp) > $signed(cache_stamp[slot])) begin
            cache_kind[slot] = KIND_NONE;
          end else if (cache_kind[slot] == KIND_PERM) begin
            v.blocked = 1'b1;
            v.kind = KIND_PERM;
          end else if (elapsed < backoff_model) begin
            v.blocked = 1'b1;
            v.kind = KIND_TEMP;
          end else begin
            cache_kind[slot] = KIND_NONE;
          end
        end
      end
      OP_RECORD: begin
        if (key_ok && (kind == KIND_TEMP || kind == KIND_PERM)) begin
          cache_key[slot] = key;
          cache_stamp[slot] = stamp;
          cache_kind[slot] = kind_t'(kind);
          cache_time[slot] = now;
        end
      end
      OP_CLEAR: wipe_cache();
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [63:0] key,
      input logic [63:0] stamp, input logic [1:0] kind, input logic [31:0] now);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_song_key <= key;
    in_source_stamp <= stamp;
    in_fail_kind <= kind;
    in_now_ms <= now;
    do @(posedge clk); while (!in_ready);
    expected_verdicts.push_back(predict_verdict(op, key, stamp, kind, now));
  endtask

  task automatic write_backoff(input logic [31:0] value);
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_backoff_ms <= value;
    do @(posedge clk); while (!cfg_ready);
    backoff_model = value;
    cfg_valid <= 1'b0;
  endtask

  // outputs of the block only change after the edge, so sampling here is race free
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("result with no request pending: blocked %0d, block_kind %0d",
               out_blocked, out_block_kind);
        mismatch_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_blocked !== want.blocked) begin
          $error("blocked: expected %0d, got %0d", want.blocked, out_blocked);
          mismatch_count++;
        end
        if (out_block_kind !== want.kind) begin
          $error("block_kind: expected %0d, got %0d", want.kind, out_block_kind);
          mismatch_count++;
        end
      end
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_key();
    int unsigned roll;
    logic [63:0] k;
    roll = $urandom_range(0, 99);
    if (roll < 80) return hot_keys[$urandom_range(0, HOT_KEYS - 1)];
    k = rand_word();
    if (roll < 90) k[63] = 1'b0;
    else if (roll < 95) k[63] = 1'b1;
    else k = {roll[0], 63'b0};
    return k;
  endfunction

  function automatic logic [63:0] pick_stamp();
    int unsigned roll;
    longint      s;
    roll = $urandom_range(0, 99);
    s = longint'($urandom_range(0, 40)) - 64'sd10;
    if (roll < 55) return s;
    if (roll < 70) return '0;
    if (roll < 85) return rand_word();
    if (roll < 93) return INT64_MAX;
    return INT64_MIN;
  endfunction

  task automatic test_lookup_record();
    logic [31:0] t0;
    t0 = 32'h0001_0000;
    // non-positive keys and a miss
    send_request(OP_LOOKUP, '0, '0, KIND_NONE, t0);
    send_request(OP_LOOKUP, '1, 64'd3, KIND_PERM, t0);
    send_request(OP_LOOKUP, INT64_MIN, '0, KIND_NONE, t0);
    send_request(OP_LOOKUP, INT64_MAX, '0, KIND_NONE, t0);
    // temporary failure under the reset backoff
    send_request(OP_RECORD, 64'h1234, 64'd5, KIND_TEMP, t0);
    send_request(OP_LOOKUP, 64'h1234, '0, KIND_NONE, t0 + 32'd9999);
    send_request(OP_LOOKUP, 64'h1234, 64'd5, KIND_NONE, t0 + 32'd10000);
    send_request(OP_LOOKUP, 64'h1234, '0, KIND_NONE, t0 + 32'd1);
    // permanent failure and newer source stamps
    send_request(OP_RECORD, INT64_MAX, 64'd100, KIND_PERM, t0);
    send_request(OP_LOOKUP, INT64_MAX, 64'd100, KIND_NONE, t0);
    send_request(OP_LOOKUP, INT64_MAX, -64'sd5, KIND_NONE, t0);
    send_request(OP_LOOKUP, INT64_MAX, 64'd101, KIND_NONE, t0);
    send_request(OP_LOOKUP, INT64_MAX, '0, KIND_NONE, t0);
    // tag mismatch on a shared slot, unknown stamp
    send_request(OP_RECORD, 64'h55, INT64_MIN, KIND_PERM, '1);
    send_request(OP_LOOKUP, 64'h155, '0, KIND_NONE, '0);
    send_request(OP_LOOKUP, 64'h55, '1, KIND_NONE, '0);
    send_request(OP_LOOKUP, 64'h55, 64'd1, KIND_NONE, '0);
    // ignored records
    send_request(OP_RECORD, 64'h77, 64'd9, KIND_NONE, t0);
    send_request(OP_RECORD, 64'h77, 64'd9, KIND_UNUSED, t0);
    send_request(OP_RECORD, '0, 64'd9, KIND_TEMP, t0);
    send_request(OP_RECORD, -64'sd256, 64'd9, KIND_PERM, t0);
    send_request(OP_LOOKUP, 64'h77, '0, KIND_NONE, t0);
    send_request(OP_LOOKUP, 64'h100, '0, KIND_NONE, t0);
    // unused opcode, then clear
    send_request(OP_RECORD, 64'h77, INT64_MAX, KIND_PERM, t0);
    send_request(OP_LOOKUP, 64'h77, INT64_MAX, KIND_NONE, t0);
    send_request(OP_UNUSED, 64'h77, '0, KIND_NONE, t0);
    send_request(OP_LOOKUP, 64'h77, '0, KIND_NONE, t0);
    send_request(OP_CLEAR, 64'h77, '1, KIND_UNUSED, '1);
    send_request(OP_LOOKUP, 64'h77, '0, KIND_NONE, t0);
  endtask

  task automatic test_backoff_limits();
    idle_pct = 6;
    stall_pct = 6;
    write_backoff('0);
    send_request(OP_RECORD, 64'h99, 64'd1, KIND_TEMP, 32'd100);
    send_request(OP_LOOKUP, 64'h99, '0, KIND_NONE, 32'd100);
    write_backoff(32'd1);
    send_request(OP_RECORD, 64'h99, 64'd1, KIND_TEMP, 32'd100);
    send_request(OP_LOOKUP, 64'h99, '0, KIND_NONE, 32'd100);
    send_request(OP_LOOKUP, 64'h99, '0, KIND_NONE, 32'd101);
    write_backoff('1);
    send_request(OP_RECORD, 64'h99, 64'd1, KIND_TEMP, 32'd1);
    send_request(OP_LOOKUP, 64'h99, '0, KIND_NONE, 32'd0);
    send_request(OP_RECORD, 64'h99, 64'd1, KIND_TEMP, 32'd5);
    send_request(OP_LOOKUP, 64'h99, '0, KIND_NONE, 32'd3);
    // elapsed time across the clock wrap
    write_backoff(32'd10000);
    send_request(OP_RECORD, 64'h99, 64'd1, KIND_TEMP, 32'hFFFF_FFF0);
    send_request(OP_LOOKUP, 64'h99, '0, KIND_NONE, 32'h0000_0010);
    send_request(OP_LOOKUP, 64'h99, '0, KIND_NONE, 32'd9984);
  endtask

  task automatic test_random_traffic();
    logic [31:0] backoff_plan [8];
    logic [63:0] k;
    logic [31:0] clock_ms;
    logic [31:0] step_max;
    logic [1:0]  op;
    logic [1:0]  kind;
    int unsigned roll;
    backoff_plan = '{32'd10000, 32'd250, 32'd0, 32'd4000, 32'hFFFF_FFFF, 32'd1,
                     32'd60000, 32'd1000};
    // pairs of keys share a slot
    for (int i = 0; i < HOT_KEYS; i++) begin
      k = rand_word();
      k[63] = 1'b0;
      if (i % 2 == 1) k[IDX_W-1:0] = hot_keys[i-1][IDX_W-1:0];
      if (k == '0) k = 64'd1;
      hot_keys[i] = k;
    end
    clock_ms = $urandom();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 56;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 56;
        end
        default: begin
          idle_pct = 6;
          stall_pct = 6;
        end
      endcase
      write_backoff(backoff_plan[phase]);
      if (backoff_plan[phase] == '0) step_max = 32'd20;
      else if (backoff_plan[phase] > 32'd200000) step_max = 32'd50000;
      else step_max = backoff_plan[phase] / 3 + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) clock_ms += $urandom();
        else clock_ms += $urandom_range(0, step_max);
        roll = $urandom_range(0, 99);
        if (roll < 55) op = OP_LOOKUP;
        else if (roll < 96) op = OP_RECORD;
        else if (roll < 97) op = OP_CLEAR;
        else op = OP_UNUSED;
        roll = $urandom_range(0, 99);
        if (op != OP_RECORD) kind = 2'($urandom_range(0, 3));
        else if (roll < 45) kind = KIND_TEMP;
        else if (roll < 85) kind = KIND_PERM;
        else if (roll < 93) kind = KIND_NONE;
        else kind = KIND_UNUSED;
        send_request(op, pick_key(), pick_stamp(), kind, clock_ms);
      end
    end
  endtask

  initial begin
    wipe_cache();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_lookup_record();
    test_backoff_limits();
    test_random_traffic();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("negative_cache_with_backoff: match");
    end else begin
      $display("negative_cache_with_backoff: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("negative_cache_with_backoff: mismatch");
    $finish;
  end

endmodule

// ----- negative_cache_with_backoff.f -----
rtl/core/ncb_pkg.sv
rtl/core/ncb_ram.sv
rtl/core/ncb_eval.sv
rtl/core/negative_cache_with_backoff.sv
bench/negative_cache_with_backoff_tb.sv
